// ----- rtl/dce_pkg.sv -----
// Package: shared types, constants and configuration indexes of the compressor/expander.
`default_nettype none
package dce_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int NOISE_GAIN_DEF = 16384;
	localparam int GAIN_W = 24;
	localparam int THR_W = 15;
	localparam int COEF_W = 16;
	localparam int CFG_DW = 24;
	localparam int CFG_AW = 3;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd65536;

	localparam logic [CFG_AW-1:0] REG_CMP_THR = 3'd0;
	localparam logic [CFG_AW-1:0] REG_EXP_THR = 3'd1;
	localparam logic [CFG_AW-1:0] REG_NOISE_THR = 3'd2;
	localparam logic [CFG_AW-1:0] REG_FLOOR = 3'd3;
	localparam logic [CFG_AW-1:0] REG_CEIL = 3'd4;
	localparam logic [CFG_AW-1:0] REG_CMP_ATK = 3'd5;
	localparam logic [CFG_AW-1:0] REG_EXP_ATK = 3'd6;
	localparam logic [CFG_AW-1:0] REG_REL = 3'd7;

	typedef enum logic [1:0] {
		RGN_COMP = 2'd0,
		RGN_EXP = 2'd1,
		RGN_NOISE = 2'd2,
		RGN_OTHER = 2'd3
	} region_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;      // capture input word, start first multiply
		logic classify;  // level known: pick region, start divider if needed
		logic div_step;  // one quotient bit
		logic target;    // form gain target
		logic err_mul;   // multiply gain error by coefficient
		logic gain_upd;  // commit new gain
		logic out_mul;   // rescale sample with chosen gain
		logic finish;    // saturate and load output register
	} dce_cmd_t;

	typedef struct packed {
		logic needs_div;
		logic div_last;
	} dce_sts_t;
endpackage
`default_nettype wire

// ----- rtl/dynamic_compressor_expander_top.sv -----
// Sequence: load, level, then for compress/expand a 31-step divider and the gain target, then
// error multiply, gain update, output multiply, and output once the output register is free.
// The input is taken again once the result sits in the output register.
// Reset: asynchronous, active low; gain returns to unity, registers to defaults.
// No clearing pass is needed after reset.
`default_nettype none
module dynamic_compressor_expander_top #(
	parameter int SAMPLE_BITS = dce_pkg::SAMPLE_BITS_DEF,
	parameter int NOISE_GAIN_Q16 = dce_pkg::NOISE_GAIN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,  // sample_in
	input  wire logic                        s_tlast,  // block_end
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [47:0]                      m_tdata,  // sample_out[15:0], gain_out[39:16]
	output logic                             m_tlast,  // block_end_out
	input  wire logic                        cfg_we,
	input  wire logic [dce_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [dce_pkg::CFG_DW-1:0]  cfg_wdata
);
	import dce_pkg::*;

	dce_cmd_t cmd;
	dce_sts_t sts;
	logic busy, last_q, out_free;
	logic [THR_W-1:0] cmp_thr_q, exp_thr_q, noise_thr_q;
	logic [16:0] floor_q;
	logic [GAIN_W-1:0] ceil_q, gain_o;
	logic [COEF_W-1:0] cmp_atk_q, exp_atk_q, rel_q;
	logic signed [SAMPLE_BITS-1:0] y_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_thr_q <= 15'd24576;
			exp_thr_q <= 15'd8192;
			noise_thr_q <= 15'd256;
			floor_q <= 17'd16384;
			ceil_q <= 24'd262144;
			cmp_atk_q <= 16'd6554;
			exp_atk_q <= 16'd655;
			rel_q <= 16'd66;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CMP_THR: cmp_thr_q <= cfg_wdata[THR_W-1:0];
				REG_EXP_THR: exp_thr_q <= cfg_wdata[THR_W-1:0];
				REG_NOISE_THR: noise_thr_q <= cfg_wdata[THR_W-1:0];
				REG_FLOOR: floor_q <= cfg_wdata[16:0];
				REG_CEIL: ceil_q <= cfg_wdata;
				REG_CMP_ATK: cmp_atk_q <= cfg_wdata[COEF_W-1:0];
				REG_EXP_ATK: exp_atk_q <= cfg_wdata[COEF_W-1:0];
				REG_REL: rel_q <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !busy;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			last_q <= s_tlast;
		end
		if (cmd.finish) begin
			m_tlast <= last_q;
		end
	end

	dce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(s_tvalid), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	dce_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .NOISE_GAIN_Q16(NOISE_GAIN_Q16)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.x_in(SAMPLE_BITS'(s_tdata)),
		.cmp_thr(cmp_thr_q), .exp_thr(exp_thr_q), .noise_thr(noise_thr_q),
		.floor_gain(floor_q), .ceil_gain(ceil_q),
		.cmp_atk(cmp_atk_q), .exp_atk(exp_atk_q), .rel_coef(rel_q),
		.y_out(y_o), .gain_out(gain_o)
	);

	assign m_tdata = {8'd0, gain_o, 16'(y_o)};
endmodule
`default_nettype wire

// ----- rtl/dce_ctrl.sv -----
// Controller: sequences load, level, divide, gain update and output steps.
`default_nettype none
module dce_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              out_free,
	input  wire dce_pkg::dce_sts_t sts,
	output dce_pkg::dce_cmd_t      cmd,
	output logic                   busy
);
	import dce_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_LEVEL  = 8'b0000_0010,
		ST_DIV    = 8'b0000_0100,
		ST_TARGET = 8'b0000_1000,
		ST_ERR    = 8'b0001_0000,
		ST_GAIN   = 8'b0010_0000,
		ST_OUT    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				cmd.classify = 1'b1;
				state_d = sts.needs_div ? ST_DIV : ST_ERR;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_TARGET;
				end
			end
			ST_TARGET: begin
				cmd.target = 1'b1;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.err_mul = 1'b1;
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain_upd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.out_mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/dce_datapath.sv -----
// Datapath: gain register, shared multiplier, serial divider and saturation.
`default_nettype none
module dce_datapath #(
	parameter int SAMPLE_BITS = dce_pkg::SAMPLE_BITS_DEF,
	parameter int NOISE_GAIN_Q16 = dce_pkg::NOISE_GAIN_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dce_pkg::dce_cmd_t            cmd,
	output dce_pkg::dce_sts_t                 sts,
	input  wire logic signed [SAMPLE_BITS-1:0] x_in,
	input  wire logic [dce_pkg::THR_W-1:0]    cmp_thr,
	input  wire logic [dce_pkg::THR_W-1:0]    exp_thr,
	input  wire logic [dce_pkg::THR_W-1:0]    noise_thr,
	input  wire logic [16:0]                  floor_gain,
	input  wire logic [dce_pkg::GAIN_W-1:0]   ceil_gain,
	input  wire logic [dce_pkg::COEF_W-1:0]   cmp_atk,
	input  wire logic [dce_pkg::COEF_W-1:0]   exp_atk,
	input  wire logic [dce_pkg::COEF_W-1:0]   rel_coef,
	output logic signed [SAMPLE_BITS-1:0]     y_out,
	output logic [dce_pkg::GAIN_W-1:0]        gain_out
);
	import dce_pkg::*;

	localparam int MW = SAMPLE_BITS + GAIN_W;    // |x|*gain product width
	localparam int AW = MW - 16;                 // scaled magnitude width
	localparam int NUMW = THR_W + 16;            // divider numerator width
	localparam int CW = $clog2(NUMW + 1);
	localparam logic [AW-1:0] FS = AW'(1) << (SAMPLE_BITS - 1);
	localparam logic [GAIN_W-1:0] NG = GAIN_W'(NOISE_GAIN_Q16);

	logic               neg_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [GAIN_W-1:0]  gain_q, old_q;
	logic [AW-1:0]      lvl_q;
	region_t            rgn_q;
	logic [NUMW-1:0]    num_q, quo_q;
	logic [AW:0]        rem_q;
	logic [CW-1:0]      cnt_q;
	logic               eneg_q;
	logic [GAIN_W-1:0]  emag_q;
	logic [GAIN_W-1:0]  delta_q;
	logic [AW-1:0]      ymag_q;

	logic [MW-1:0]      prod;
	logic [SAMPLE_BITS-1:0] xmag;
	logic [AW-1:0]      lvl;
	logic [AW:0]        rtry;
	logic [GAIN_W-1:0]  qsat, tgt, mul_a, coef;
	logic [GAIN_W+COEF_W-1:0] eprod;
	logic signed [GAIN_W+1:0] gnew;
	logic [AW-1:0]      ysat;

	assign xmag = x_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_in) : x_in;

	// The output multiply uses the noise gain, the old gain for other levels,
	// or the freshly updated gain in the compress and expand regions.
	always_comb begin
		case (1'b1)
			cmd.load: mul_a = gain_q;
			default: mul_a = (rgn_q == RGN_NOISE) ? NG :
				((rgn_q == RGN_OTHER) ? old_q : gain_q);
		endcase
	end
	assign prod = MW'((cmd.load ? xmag : mag_q)) * MW'(mul_a);
	assign lvl = prod[MW-1:16];

	assign sts.needs_div = (lvl_q > AW'(cmp_thr)) ||
		((lvl_q < AW'(exp_thr)) && (lvl_q > AW'(noise_thr)));
	assign sts.div_last = (cnt_q == CW'(1));

	// Restoring division, one quotient bit per cycle, numerator MSB first.
	assign rtry = {rem_q[AW-1:0], num_q[NUMW-1]} - {1'b0, lvl_q};

	always_comb begin
		qsat = (|quo_q[NUMW-1:GAIN_W]) ? '1 : quo_q[GAIN_W-1:0];
		if (rgn_q == RGN_COMP) begin
			tgt = (qsat < GAIN_W'(floor_gain)) ? GAIN_W'(floor_gain) : qsat;
		end else begin
			tgt = (qsat > ceil_gain) ? ceil_gain : qsat;
		end
	end

	always_comb begin
		case (rgn_q)
			RGN_COMP: coef = GAIN_W'(cmp_atk);
			RGN_EXP: coef = GAIN_W'(exp_atk);
			default: coef = GAIN_W'(rel_coef);
		endcase
	end
	assign eprod = emag_q[GAIN_W-1:0] * coef[COEF_W-1:0];

	always_comb begin
		if (eneg_q) begin
			gnew = $signed({2'b00, old_q}) - $signed({2'b00, delta_q});
		end else begin
			gnew = $signed({2'b00, old_q}) + $signed({2'b00, delta_q});
		end
	end

	always_comb begin
		if (rgn_q == RGN_COMP) begin
			ysat = (ymag_q >= FS) ? FS - AW'(1) : ymag_q;
		end else if (!neg_q && ymag_q >= FS) begin
			ysat = FS - AW'(1);
		end else if (neg_q && ymag_q > FS) begin
			ysat = FS;
		end else begin
			ysat = ymag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= UNITY_GAIN;
		end else if (cmd.gain_upd) begin
			if (gnew < 0) begin
				gain_q <= '0;
			end else if (gnew > $signed({2'b00, {GAIN_W{1'b1}}})) begin
				gain_q <= '1;
			end else begin
				gain_q <= gnew[GAIN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= x_in[SAMPLE_BITS-1];
			mag_q <= xmag;
			old_q <= gain_q;
			lvl_q <= lvl;
		end
		if (cmd.classify) begin
			if (lvl_q > AW'(cmp_thr)) begin
				rgn_q <= RGN_COMP;
				num_q <= {exp_thr, 16'd0};
			end else if ((lvl_q < AW'(exp_thr)) && (lvl_q > AW'(noise_thr))) begin
				rgn_q <= RGN_EXP;
				num_q <= {cmp_thr, 16'd0};
			end else begin
				rgn_q <= (lvl_q < AW'(noise_thr)) ? RGN_NOISE : RGN_OTHER;
				eneg_q <= (gain_q > UNITY_GAIN);
				emag_q <= (gain_q > UNITY_GAIN) ? gain_q - UNITY_GAIN : UNITY_GAIN - gain_q;
			end
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= CW'(NUMW);
		end
		if (cmd.div_step) begin
			if (!rtry[AW]) begin
				rem_q <= rtry;
				quo_q <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[AW-1:0], num_q[NUMW-1]};
				quo_q <= {quo_q[NUMW-2:0], 1'b0};
			end
			num_q <= {num_q[NUMW-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.target) begin
			eneg_q <= (old_q > tgt);
			emag_q <= (old_q > tgt) ? old_q - tgt : tgt - old_q;
		end
		if (cmd.err_mul) begin
			delta_q <= GAIN_W'(eprod >> 16);
		end
		if (cmd.out_mul) begin
			ymag_q <= lvl;
		end
		if (cmd.finish) begin
			y_out <= neg_q ? SAMPLE_BITS'(-ysat) : SAMPLE_BITS'(ysat);
			gain_out <= gain_q;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/dce_checker.sv -----
// Checker: port-level properties of the compressor/expander, bound to the top level.
`default_nettype none
module dce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while one is in work");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:40] == 8'd0)
		else $error("padding bits not zero");
	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after accept");
endmodule

bind dynamic_compressor_expander_top dce_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- verif/tb_dynamic_compressor_expander_top.sv -----
// Testbench for the dynamic compressor/expander: random and directed samples checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_dynamic_compressor_expander_top;
	import dce_pkg::*;

	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} sample_word_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [23:0] gain;
		logic        last;
	} result_word_t;

	localparam longint GAIN_LIMIT = 64'd16777215;
	localparam longint UNITY = 64'd65536;
	localparam longint FULL_SCALE = 64'd32768;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic m_tlast;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	dynamic_compressor_expander_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Predictor state: thresholds, gains, coefficients and the running gain.
	longint cmp_thr, exp_thr, noise_thr, floor_gain, ceil_gain;
	longint cmp_atk, exp_atk, rel_coef, gain_now;

	sample_word_t pending_words[$];
	result_word_t expected_results[$];
	int errors;
	int cycles;
	bit no_idle;
	bit hold_send;

	function automatic longint mul_q16(longint v, longint f);
		longint m;
		m = ((v < 0) ? -v : v) * f;
		m = m >>> 16;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint gain_toward(longint g, longint tgt, longint coef);
		return clip(g + mul_q16(tgt - g, coef), 0, GAIN_LIMIT);
	endfunction

	function automatic longint gain_ratio(longint num, longint lvl);
		longint q;
		q = (num << 16) / lvl;
		return (q > GAIN_LIMIT) ? GAIN_LIMIT : q;
	endfunction

	task automatic predict_sample(input sample_word_t w);
		longint x, g, lvl, y, tgt;
		result_word_t r;
		x = longint'($signed(w.sample));
		g = gain_now;
		lvl = mul_q16(x, g);
		if (lvl < 0)
			lvl = -lvl;
		if (lvl > cmp_thr) begin
			tgt = gain_ratio(exp_thr, lvl);
			if (tgt < floor_gain)
				tgt = floor_gain;
			gain_now = gain_toward(g, tgt, cmp_atk);
			y = mul_q16(x, gain_now);
			if (!(y > -FULL_SCALE && y < FULL_SCALE))
				y = (y < 0) ? -(FULL_SCALE - 1) : FULL_SCALE - 1;
		end else if (lvl < exp_thr && lvl > noise_thr) begin
			tgt = gain_ratio(cmp_thr, lvl);
			if (tgt > ceil_gain)
				tgt = ceil_gain;
			gain_now = gain_toward(g, tgt, exp_atk);
			y = clip(mul_q16(x, gain_now), -FULL_SCALE, FULL_SCALE - 1);
		end else begin
			y = mul_q16(x, (lvl < noise_thr) ? longint'(NOISE_GAIN_DEF) : g);
			y = clip(y, -FULL_SCALE, FULL_SCALE - 1);
			gain_now = gain_toward(g, UNITY, rel_coef);
		end
		r.sample = y[15:0];
		r.gain = gain_now[23:0];
		r.last = w.last;
		expected_results.push_back(r);
	endtask

	// Driver: one word per handshake, random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_words.size() > 0 && !hold_send
					&& (no_idle || $urandom_range(99) >= 14)) begin
				sample_word_t w;
				w = pending_words.pop_front();
				predict_sample(w);
				s_tvalid <= 1'b1;
				s_tdata <= w.sample;
				s_tlast <= w.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_word_t got, want;
				got.sample = m_tdata[15:0];
				got.gain = m_tdata[39:16];
				got.last = m_tlast;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word sample=%h gain=%h last=%b",
						$time, got.sample, got.gain, got.last);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.sample !== want.sample) begin
						$display("%0t: sample_out expected %h actual %h",
							$time, want.sample, got.sample);
						errors++;
					end
					if (got.gain !== want.gain) begin
						$display("%0t: gain_out expected %h actual %h",
							$time, want.gain, got.gain);
						errors++;
					end
					if (got.last !== want.last) begin
						$display("%0t: block_end_out expected %b actual %b",
							$time, want.last, got.last);
						errors++;
					end
				end
			end
			m_tready <= no_idle || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic reg_write(input logic [CFG_AW-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[CFG_DW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CMP_THR: cmp_thr = val & 64'h7FFF;
			REG_EXP_THR: exp_thr = val & 64'h7FFF;
			REG_NOISE_THR: noise_thr = val & 64'h7FFF;
			REG_FLOOR: floor_gain = val & 64'h1FFFF;
			REG_CEIL: ceil_gain = val & 64'hFFFFFF;
			REG_CMP_ATK: cmp_atk = val & 64'hFFFF;
			REG_EXP_ATK: exp_atk = val & 64'hFFFF;
			default: rel_coef = val & 64'hFFFF;
		endcase
	endtask

	task automatic drain();
		wait (pending_words.size() == 0);
		while (expected_results.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic queue_sample(input longint s, input bit l);
		sample_word_t w;
		w.sample = s[15:0];
		w.last = l;
		pending_words.push_back(w);
	endtask

	// Mostly signal-like runs of slowly varying amplitude, some raw noise.
	task automatic queue_random(input int n);
		int amp, k;
		for (k = 0; k < n; k++) begin
			if (k % 32 == 0)
				amp = (1 << $urandom_range(15, 0)) - 1;
			if ($urandom_range(9) < 2)
				queue_sample($urandom, $urandom_range(1));
			else
				queue_sample(longint'($urandom_range(amp, 0))
					* (($urandom_range(1)) ? -1 : 1), (k % 16) == 15);
		end
	endtask

	initial begin
		int ph;
		errors = 0;
		cycles = 0;
		no_idle = 1'b0;
		hold_send = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cmp_thr = 24576;
		exp_thr = 8192;
		noise_thr = 256;
		floor_gain = 16384;
		ceil_gain = 262144;
		cmp_atk = 6554;
		exp_atk = 655;
		rel_coef = 66;
		gain_now = UNITY;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every region, samples equal to the default thresholds.
		queue_sample(0, 0);
		queue_sample(32767, 0);
		queue_sample(-32768, 1);
		queue_sample(-32768, 0);
		queue_sample(1, 0);
		queue_sample(-1, 0);
		queue_sample(256, 0);
		queue_sample(255, 0);
		queue_sample(300, 0);
		queue_sample(-5000, 0);
		queue_sample(8192, 0);
		queue_sample(24576, 0);
		queue_sample(24577, 0);
		queue_sample(16'h5555, 0);
		queue_sample(16'hAAAA, 1);
		queue_sample(12000, 0);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_CMP_THR, 32767);
					reg_write(REG_EXP_THR, 32767);
					reg_write(REG_NOISE_THR, 0);
					reg_write(REG_FLOOR, 65536);
					reg_write(REG_CEIL, 16777215);
					reg_write(REG_CMP_ATK, 65535);
					reg_write(REG_EXP_ATK, 65535);
					reg_write(REG_REL, 65535);
				end
				1: begin
					reg_write(REG_CMP_THR, 0);
					reg_write(REG_EXP_THR, 0);
					reg_write(REG_NOISE_THR, 32767);
					reg_write(REG_FLOOR, 0);
					reg_write(REG_CEIL, 65536);
					reg_write(REG_CMP_ATK, 0);
					reg_write(REG_EXP_ATK, 0);
					reg_write(REG_REL, 0);
				end
				default: begin
					reg_write(REG_CMP_THR, $urandom_range(32767, 8000));
					reg_write(REG_EXP_THR, $urandom_range(12000, 500));
					reg_write(REG_NOISE_THR, $urandom_range(600));
					reg_write(REG_FLOOR, $urandom_range(65536));
					reg_write(REG_CEIL, $urandom_range(16777215, 65536));
					reg_write(REG_CMP_ATK, $urandom_range(65535));
					reg_write(REG_EXP_ATK, $urandom_range(65535));
					reg_write(REG_REL, $urandom_range(65535));
				end
			endcase
			no_idle = (ph == 3);
			queue_random(ph < 2 ? 120 : 300);
			if (ph == 4) begin
				// Hold the sender until every result is back.
				wait (pending_words.size() < 150);
				hold_send = 1'b1;
				while (expected_results.size() != 0)
					@(posedge clk);
				hold_send = 1'b0;
			end
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/dce_pkg.sv
rtl/dce_ctrl.sv
rtl/dce_datapath.sv
rtl/dynamic_compressor_expander_top.sv
rtl/dce_checker.sv
verif/tb_dynamic_compressor_expander_top.sv
